// ===== src/contiguous_fit_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_macros
// assertion helpers used by the allocator datapath
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa assertion failed");

// next-cycle implication
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa assertion failed");

`endif

// ===== src/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// types and codes of the contiguous fit allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam logic [2:0] FUNC_REQUEST  = 3'd0;
  localparam logic [2:0] FUNC_RELEASE  = 3'd1;
  localparam logic [2:0] FUNC_FIND     = 3'd2;
  localparam logic [2:0] FUNC_HOLES    = 3'd3;
  localparam logic [2:0] FUNC_SEGMENTS = 3'd4;

  localparam logic [3:0] KIND_ALLOC = 4'd0;
  localparam logic [3:0] KIND_FREED = 4'd1;
  localparam logic [3:0] KIND_FOUND = 4'd2;
  localparam logic [3:0] KIND_FAIL  = 4'd3;
  localparam logic [3:0] KIND_FAULT = 4'd4;
  localparam logic [3:0] KIND_HOLE  = 4'd5;
  localparam logic [3:0] KIND_SEG   = 4'd6;
  localparam logic [3:0] KIND_NONE  = 4'd7;
  localparam logic [3:0] KIND_FULL  = 4'd8;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  localparam logic CFG_REGION = 1'b0;
  localparam logic CFG_POLICY = 1'b1;

  localparam logic [30:0] REGION_RESET = 31'd1048576;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] owner_tag;
    logic [30:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] tag_out;
    logic [30:0] length_out;
    logic [29:0] base_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

endpackage

// ===== src/cfa_stream_if.sv =====
// ----------------------------------------------------------------------------
// cfa_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface cfa_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/cfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfa_ctrl
// command sequencer: load, table scan, finish
// ----------------------------------------------------------------------------
module cfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfa_pkg::status_t status_i,
  output cfa_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_step) state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/cfa_datapath.sv =====
// ----------------------------------------------------------------------------
// cfa_datapath, whose scan waits while the result register is full
// segment table, one-entry-per-cycle scan, placement choice, result register
// ----------------------------------------------------------------------------
`include "contiguous_fit_allocator_macros.svh"

module cfa_datapath #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_BITS    = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [30:0]         cfg_wdata_i,
  input  cfa_pkg::in_item_t   in_data_i,
  input  cfa_pkg::cmd_t       cmd_i,
  output cfa_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfa_pkg::out_item_t  out_data_o
);

  localparam int KW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [30:0] SPAN = 31'(64'd1 << ADDR_BITS);
  localparam logic [KW-1:0] MAX_CNT = KW'(MAX_SEGMENTS);

  // configuration
  logic [30:0] region_q;
  logic [1:0]  policy_q;

  // table, address ordered, valid entries packed low
  logic [63:0]          tag_tab_q  [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] base_tab_q [MAX_SEGMENTS];
  logic [30:0]          len_tab_q  [MAX_SEGMENTS];
  logic [KW-1:0]        cnt_q;
  logic [ADDR_BITS-1:0] rover_q;

  // command under work
  logic [2:0]  func_q;
  logic [63:0] tag_q;
  logic [30:0] len_q;
  logic [KW-1:0] k_q;
  logic [31:0] prev_end_q;

  // placement candidates
  logic                 have_q, any_q, after_q;
  logic [KW-1:0]        pick_k_q, any_k_q, after_k_q;
  logic [ADDR_BITS-1:0] pick_start_q, any_start_q, after_start_q;
  logic [30:0]          pick_size_q;

  // tag hit
  logic                 hit_q;
  logic [KW-1:0]        hit_k_q;
  logic [30:0]          hit_len_q;
  logic [ADDR_BITS-1:0] hit_base_q;

  // pending hole, held back until its last flag is known
  logic                 hb_v_q;
  logic [30:0]          hb_len_q;
  logic [ADDR_BITS-1:0] hb_base_q;

  logic                 ov_q;
  cfa_pkg::out_item_t   od_q;

  logic [IW-1:0] idx;
  logic          at_end, out_free, fits, after_ok, precheck_fail, match, last_step;
  logic [30:0]   lim, sz;
  logic [31:0]   rd_base, e_raw, e_cl, seg_end;
  logic [ADDR_BITS-1:0] hole_start;
  logic                 ch_have;
  logic [KW-1:0]        ch_k;
  logic [ADDR_BITS-1:0] ch_start;
  logic                 emit;
  cfa_pkg::out_item_t   emit_data;

  assign lim      = (region_q > SPAN) ? SPAN : region_q;
  assign idx      = k_q[IW-1:0];
  assign at_end   = (k_q == cnt_q);
  assign out_free = !ov_q || out_ready_i;

  assign rd_base    = 32'(base_tab_q[idx]);
  assign e_raw      = at_end ? {1'b0, lim} : rd_base;
  assign e_cl       = (e_raw > {1'b0, lim}) ? {1'b0, lim} : e_raw;
  assign sz         = (e_cl > prev_end_q) ? 31'(e_cl - prev_end_q) : 31'd0;
  assign hole_start = prev_end_q[ADDR_BITS-1:0];
  assign seg_end    = rd_base + 32'(len_tab_q[idx]);

  assign fits          = (sz != 31'd0) && (sz >= len_q);
  assign after_ok      = (prev_end_q >= 32'(rover_q));
  assign precheck_fail = (len_q == 31'd0) || (len_q > lim) || (cnt_q == MAX_CNT);
  assign match         = !at_end && (tag_tab_q[idx] == tag_q);

  always_comb begin
    unique case (func_q)
      cfa_pkg::FUNC_REQUEST:  last_step = precheck_fail || at_end;
      cfa_pkg::FUNC_RELEASE,
      cfa_pkg::FUNC_FIND:     last_step = at_end || match;
      cfa_pkg::FUNC_HOLES,
      cfa_pkg::FUNC_SEGMENTS: last_step = at_end;
      default:                last_step = 1'b1;
    endcase
  end

  assign status_o.last_step = last_step;
  assign status_o.out_free  = out_free;

  // final placement choice
  always_comb begin
    ch_have  = have_q;
    ch_k     = pick_k_q;
    ch_start = pick_start_q;
    unique case (policy_q)
      cfa_pkg::POL_FIRST: begin
        ch_have  = any_q;
        ch_k     = any_k_q;
        ch_start = any_start_q;
      end
      cfa_pkg::POL_NEXT: begin
        ch_have  = after_q || any_q;
        ch_k     = after_q ? after_k_q : any_k_q;
        ch_start = after_q ? after_start_q : any_start_q;
      end
      default: ;
    endcase
  end

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    if (cmd_i.step) begin
      if (func_q == cfa_pkg::FUNC_HOLES && sz != 31'd0 && hb_v_q) begin
        emit                 = 1'b1;
        emit_data.kind       = cfa_pkg::KIND_HOLE;
        emit_data.length_out = hb_len_q;
        emit_data.base_out   = 30'(hb_base_q);
      end else if (func_q == cfa_pkg::FUNC_SEGMENTS && !at_end) begin
        emit                 = 1'b1;
        emit_data.kind       = cfa_pkg::KIND_SEG;
        emit_data.tag_out    = tag_tab_q[idx];
        emit_data.length_out = len_tab_q[idx];
        emit_data.base_out   = 30'(base_tab_q[idx]);
        emit_data.last       = (k_q + KW'(1) == cnt_q);
      end
    end else if (cmd_i.finish) begin
      emit           = 1'b1;
      emit_data.last = 1'b1;
      unique case (func_q)
        cfa_pkg::FUNC_REQUEST: begin
          emit_data.tag_out    = tag_q;
          emit_data.length_out = len_q;
          if (precheck_fail || !ch_have) begin
            emit_data.kind = cfa_pkg::KIND_FAIL;
          end else begin
            emit_data.kind     = cfa_pkg::KIND_ALLOC;
            emit_data.base_out = 30'(ch_start);
          end
        end
        cfa_pkg::FUNC_RELEASE: begin
          emit_data.tag_out = tag_q;
          if (hit_q) begin
            emit_data.kind       = cfa_pkg::KIND_FREED;
            emit_data.length_out = hit_len_q;
            emit_data.base_out   = 30'(hit_base_q);
          end else begin
            emit_data.kind = cfa_pkg::KIND_FAIL;
          end
        end
        cfa_pkg::FUNC_FIND: begin
          if (hit_q) begin
            emit_data.kind       = cfa_pkg::KIND_FOUND;
            emit_data.tag_out    = tag_q;
            emit_data.length_out = hit_len_q;
            emit_data.base_out   = 30'(hit_base_q);
          end else begin
            emit_data.kind = cfa_pkg::KIND_FAULT;
          end
        end
        cfa_pkg::FUNC_HOLES: begin
          if (hb_v_q) begin
            emit_data.kind       = cfa_pkg::KIND_HOLE;
            emit_data.length_out = hb_len_q;
            emit_data.base_out   = 30'(hb_base_q);
          end else begin
            emit_data.kind = cfa_pkg::KIND_FULL;
          end
        end
        cfa_pkg::FUNC_SEGMENTS: begin
          // segments already went out during the scan
          emit           = (cnt_q == '0);
          emit_data.kind = cfa_pkg::KIND_NONE;
        end
        default: emit_data.kind = cfa_pkg::KIND_FAULT;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i) begin
    if (emit) od_q <= emit_data;
  end

  // control and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= cfa_pkg::REGION_RESET;
      policy_q <= cfa_pkg::POL_FIRST;
      cnt_q    <= '0;
      rover_q  <= '0;
      ov_q     <= 1'b0;
      k_q      <= '0;
      have_q   <= 1'b0;
      any_q    <= 1'b0;
      after_q  <= 1'b0;
      hit_q    <= 1'b0;
      hb_v_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cfa_pkg::CFG_REGION) region_q <= cfg_wdata_i;
        else policy_q <= cfg_wdata_i[1:0];
      end
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;

      if (cmd_i.load) begin
        k_q     <= '0;
        have_q  <= 1'b0;
        any_q   <= 1'b0;
        after_q <= 1'b0;
        hit_q   <= 1'b0;
        hb_v_q  <= 1'b0;
      end else if (cmd_i.step) begin
        k_q <= k_q + KW'(1);
        if (func_q == cfa_pkg::FUNC_REQUEST && fits) begin
          any_q <= 1'b1;
          if (!after_q && after_ok) after_q <= 1'b1;
          if (!have_q || (policy_q == cfa_pkg::POL_BEST && sz < pick_size_q) ||
              (policy_q == cfa_pkg::POL_WORST && sz > pick_size_q)) begin
            have_q <= 1'b1;
          end
        end
        if ((func_q == cfa_pkg::FUNC_RELEASE || func_q == cfa_pkg::FUNC_FIND) && match) begin
          hit_q <= 1'b1;
        end
        if (func_q == cfa_pkg::FUNC_HOLES && sz != 31'd0) hb_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        if (func_q == cfa_pkg::FUNC_REQUEST && !precheck_fail && ch_have) begin
          cnt_q   <= cnt_q + KW'(1);
          rover_q <= ch_start + ADDR_BITS'(len_q);
        end
        if (func_q == cfa_pkg::FUNC_RELEASE && hit_q) cnt_q <= cnt_q - KW'(1);
      end
    end
  end

  // payload of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= in_data_i.func;
      tag_q      <= in_data_i.owner_tag;
      len_q      <= in_data_i.request_length;
      prev_end_q <= '0;
    end else if (cmd_i.step) begin
      prev_end_q <= seg_end;
      if (func_q == cfa_pkg::FUNC_REQUEST && fits) begin
        if (!any_q) begin
          any_k_q     <= k_q;
          any_start_q <= hole_start;
        end
        if (!after_q && after_ok) begin
          after_k_q     <= k_q;
          after_start_q <= hole_start;
        end
        if (!have_q || (policy_q == cfa_pkg::POL_BEST && sz < pick_size_q) ||
            (policy_q == cfa_pkg::POL_WORST && sz > pick_size_q)) begin
          pick_k_q     <= k_q;
          pick_start_q <= hole_start;
          pick_size_q  <= sz;
        end
      end
      if (match) begin
        hit_k_q    <= k_q;
        hit_len_q  <= len_tab_q[idx];
        hit_base_q <= base_tab_q[idx];
      end
      if (sz != 31'd0) begin
        hb_len_q  <= sz;
        hb_base_q <= hole_start;
      end
    end
  end

  // table insert and delete, each entry moves only from a neighbor
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && func_q == cfa_pkg::FUNC_REQUEST && !precheck_fail && ch_have) begin
      for (int j = 0; j < MAX_SEGMENTS; j++) begin
        if (KW'(j) == ch_k) begin
          tag_tab_q[j]  <= tag_q;
          base_tab_q[j] <= ch_start;
          len_tab_q[j]  <= len_q;
        end else if (j > 0 && KW'(j) > ch_k && KW'(j) <= cnt_q) begin
          tag_tab_q[j]  <= tag_tab_q[(j > 0) ? j - 1 : 0];
          base_tab_q[j] <= base_tab_q[(j > 0) ? j - 1 : 0];
          len_tab_q[j]  <= len_tab_q[(j > 0) ? j - 1 : 0];
        end
      end
    end else if (cmd_i.finish && func_q == cfa_pkg::FUNC_RELEASE && hit_q) begin
      for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
        if (KW'(j) >= hit_k_q && KW'(j + 1) < cnt_q) begin
          tag_tab_q[j]  <= tag_tab_q[j + 1];
          base_tab_q[j] <= base_tab_q[j + 1];
          len_tab_q[j]  <= len_tab_q[j + 1];
        end
      end
    end
  end

  `CFA_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, emit, out_free)
  `CFA_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= MAX_CNT)
  `CFA_ASSERT_NXT(a_release_shrinks, clk_i, rst_ni,
    cmd_i.finish && func_q == cfa_pkg::FUNC_RELEASE && hit_q,
    cnt_q == $past(cnt_q) - KW'(1))

endmodule

// ===== src/contiguous_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// segment allocator with best, first, next and worst fit placement
// ----------------------------------------------------------------------------
//  port        dir   word
//  in_i        in    func, owner_tag, request_length
//  out_o       out   kind, tag_out, length_out, base_out, last
//  cfg_*       in    region_size (index 0), fit_policy (index 1)
//
//  a command runs load, then n + 1 scan steps of the table read port for n
//  stored segments, then finish, fewer steps when a tag match stops early
//  a request that fails its length or table-full check, or an unknown func,
//  runs load, one step and finish
//  reset clears table count and rover, resets configuration at once, no sweep
//  the scan and finish steps wait while the result register is full
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_BITS    = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_wdata_i,
  cfa_stream_if.sink   in_i,
  cfa_stream_if.source out_o
);

  cfa_pkg::cmd_t    cmd;
  cfa_pkg::status_t status;

  cfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
